### rtl/core/afh_pkg.sv
`default_nettype none
package afh_pkg;

  localparam int unsigned MAX_LEN = 1023;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 2);

  localparam logic [31:0] MIX_MUL  = 32'h0001003F;
  localparam logic [31:0] MIX_MUL2 = 32'(64'(MIX_MUL) * 64'(MIX_MUL));

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  localparam logic [23:0] EXT_CH_NIF = 24'h6E6966;
  localparam logic [23:0] EXT_CH_KF  = 24'h006B66;
  localparam logic [23:0] EXT_CH_DDS = 24'h646473;
  localparam logic [23:0] EXT_CH_WAV = 24'h776176;

  localparam logic [63:0] FLIP_NIF = 64'h0000_0000_0000_8000;
  localparam logic [63:0] FLIP_KF  = 64'h0000_0000_0000_0080;
  localparam logic [63:0] FLIP_DDS = 64'h0000_0000_0000_8080;
  localparam logic [63:0] FLIP_WAV = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    EXT_OTHER,
    EXT_NIF,
    EXT_KF,
    EXT_DDS,
    EXT_WAV
  } afh_ext_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_file;
    logic       has_char;
    logic       is_last;
  } afh_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       first;
    logic [7:0]       last;
    logic [7:0]       sec;
    logic             ovf;
  } afh_name_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       first;
    logic [7:0]       last;
    logic [7:0]       sec;
    logic [31:0]      mid;
    logic [31:0]      ext_hash;
    afh_ext_t         ext_kind;
    logic             ovf;
  } afh_snap_t;

  function automatic logic [31:0] hash_mix(logic [31:0] h, logic [7:0] c);
    return 32'(h * MIX_MUL) + 32'(c);
  endfunction

  // Shifts one character into the running name summary; the middle hash is
  // kept outside so that two pushes in one beat need no chained multiply.
  function automatic afh_name_t push_ch(afh_name_t s, logic [7:0] c);
    afh_name_t r;
    r = s;
    if (s.len == '0) begin
      r.first = c;
    end
    r.sec  = s.last;
    r.last = c;
    if (s.len >= LEN_W'(MAX_LEN)) begin
      r.ovf = 1'b1;
      r.len = LEN_W'(MAX_LEN + 1);
    end else begin
      r.len = s.len + LEN_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/afh_state.sv
`default_nettype none
module afh_state (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              beat_valid,
  input  wire afh_pkg::afh_beat_t beat,
  input  wire logic              out_free,
  output logic                   take,
  output logic                   snap_valid,
  output afh_pkg::afh_snap_t     snap
);
  import afh_pkg::*;

  afh_name_t        name_r, name_nxt;
  logic [31:0]      mid_r, mid_nxt;
  logic             dot_r, dot_nxt;
  logic [LEN_W-1:0] stem_len_r, stem_len_nxt;
  logic [31:0]      stem_mid_r, stem_mid_nxt;
  logic [7:0]       stem_last_r, stem_last_nxt;
  logic [7:0]       stem_sec_r, stem_sec_nxt;
  logic [31:0]      ext_hash_r, ext_hash_nxt;
  logic [2:0]       ext_len_r, ext_len_nxt;
  logic [23:0]      ext_chars_r, ext_chars_nxt;
  logic             path_r, path_nxt;
  logic             file_r, file_nxt;
  logic             snap_valid_r;
  afh_snap_t        snap_r, snap_nxt;

  logic [7:0]  cf;
  logic        hc;
  logic [31:0] mid_one, mid_two;
  logic        snap_free;

  assign snap_free  = !snap_valid_r || out_free;
  assign take       = beat_valid && (!beat.is_last || snap_free);
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  assign hc = beat.has_char && (beat.char_byte != 8'h00);

  always_comb begin
    cf = beat.char_byte;
    if (cf >= CH_UP_A && cf <= CH_UP_Z) begin
      cf = cf + CASE_OFS;
    end
    if (cf == CH_SLASH) begin
      cf = CH_BSLASH;
    end
  end

  // Two pushes in one beat (separator, then character) fold into one
  // multiply by the squared constant.
  always_comb begin
    mid_one = (name_r.len >= LEN_W'(3)) ? hash_mix(mid_r, name_r.sec) : mid_r;
    if (name_r.len >= LEN_W'(3)) begin
      mid_two = 32'(mid_r * MIX_MUL2) + 32'({24'h0, name_r.sec} * MIX_MUL)
                + 32'(name_r.last);
    end else if (name_r.len == LEN_W'(2)) begin
      mid_two = hash_mix(mid_r, name_r.last);
    end else begin
      mid_two = mid_r;
    end
  end

  always_comb begin
    name_nxt      = name_r;
    mid_nxt       = mid_r;
    dot_nxt       = dot_r;
    stem_len_nxt  = stem_len_r;
    stem_mid_nxt  = stem_mid_r;
    stem_last_nxt = stem_last_r;
    stem_sec_nxt  = stem_sec_r;
    ext_hash_nxt  = ext_hash_r;
    ext_len_nxt   = ext_len_r;
    ext_chars_nxt = ext_chars_r;
    path_nxt      = path_r;
    file_nxt      = file_r;
    snap_nxt      = snap_r;

    if (hc) begin
      if (!beat.is_file) begin
        if (!file_r) begin
          path_nxt = 1'b1;
          name_nxt = push_ch(name_r, beat.char_byte);
          mid_nxt  = mid_one;
        end
      end else begin
        file_nxt = 1'b1;
        if (cf == CH_DOT) begin
          stem_len_nxt  = name_r.len;
          stem_mid_nxt  = mid_r;
          stem_last_nxt = name_r.last;
          stem_sec_nxt  = name_r.sec;
          dot_nxt       = 1'b1;
          ext_hash_nxt  = 32'(CH_DOT);
          ext_len_nxt   = '0;
          ext_chars_nxt = '0;
        end else if (dot_r) begin
          ext_hash_nxt  = hash_mix(ext_hash_r, cf);
          ext_len_nxt   = (ext_len_r == 3'd7) ? ext_len_r : ext_len_r + 3'd1;
          ext_chars_nxt = {ext_chars_r[15:0], cf};
        end
        if (!file_r && path_r) begin
          name_nxt = push_ch(push_ch(name_r, CH_BSLASH), cf);
          mid_nxt  = mid_two;
        end else begin
          name_nxt = push_ch(name_r, cf);
          mid_nxt  = mid_one;
        end
      end
    end

    if (beat.is_last) begin
      snap_nxt.len      = dot_nxt ? stem_len_nxt : name_nxt.len;
      snap_nxt.first    = name_nxt.first;
      snap_nxt.last     = dot_nxt ? stem_last_nxt : name_nxt.last;
      snap_nxt.sec      = dot_nxt ? stem_sec_nxt : name_nxt.sec;
      snap_nxt.mid      = dot_nxt ? stem_mid_nxt : mid_nxt;
      snap_nxt.ext_hash = dot_nxt ? ext_hash_nxt : 32'h0;
      snap_nxt.ovf      = name_nxt.ovf;
      snap_nxt.ext_kind = EXT_OTHER;
      if (dot_nxt) begin
        priority if (ext_len_nxt == 3'd3 && ext_chars_nxt == EXT_CH_NIF) begin
          snap_nxt.ext_kind = EXT_NIF;
        end else if (ext_len_nxt == 3'd2 && ext_chars_nxt == EXT_CH_KF) begin
          snap_nxt.ext_kind = EXT_KF;
        end else if (ext_len_nxt == 3'd3 && ext_chars_nxt == EXT_CH_DDS) begin
          snap_nxt.ext_kind = EXT_DDS;
        end else if (ext_len_nxt == 3'd3 && ext_chars_nxt == EXT_CH_WAV) begin
          snap_nxt.ext_kind = EXT_WAV;
        end else begin
          snap_nxt.ext_kind = EXT_OTHER;
        end
      end
      // The name is finished; start the next one from a clean slate.
      name_nxt      = '0;
      mid_nxt       = '0;
      dot_nxt       = 1'b0;
      stem_len_nxt  = '0;
      stem_mid_nxt  = '0;
      stem_last_nxt = '0;
      stem_sec_nxt  = '0;
      ext_hash_nxt  = '0;
      ext_len_nxt   = '0;
      ext_chars_nxt = '0;
      path_nxt      = 1'b0;
      file_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r      <= '0;
      mid_r       <= '0;
      dot_r       <= 1'b0;
      stem_len_r  <= '0;
      stem_mid_r  <= '0;
      stem_last_r <= '0;
      stem_sec_r  <= '0;
      ext_hash_r  <= '0;
      ext_len_r   <= '0;
      ext_chars_r <= '0;
      path_r      <= 1'b0;
      file_r      <= 1'b0;
    end else if (take) begin
      name_r      <= name_nxt;
      mid_r       <= mid_nxt;
      dot_r       <= dot_nxt;
      stem_len_r  <= stem_len_nxt;
      stem_mid_r  <= stem_mid_nxt;
      stem_last_r <= stem_last_nxt;
      stem_sec_r  <= stem_sec_nxt;
      ext_hash_r  <= ext_hash_nxt;
      ext_len_r   <= ext_len_nxt;
      ext_chars_r <= ext_chars_nxt;
      path_r      <= path_nxt;
      file_r      <= file_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (take && beat.is_last) begin
      snap_valid_r <= 1'b1;
    end else if (out_free) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.is_last) begin
      snap_r <= snap_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/afh_final.sv
`default_nettype none
module afh_final (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               snap_valid,
  input  wire afh_pkg::afh_snap_t snap,
  output logic                    out_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             hash_value,
  output logic                    too_long
);
  import afh_pkg::*;

  logic        out_valid_r;
  logic [63:0] hash_r, hash_nxt;
  logic        too_long_r;
  logic [63:0] low_part;
  logic [31:0] high_part;
  logic [63:0] sum;

  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign hash_value = hash_r;
  assign too_long   = too_long_r;

  always_comb begin
    low_part = '0;
    if (snap.len != '0) begin
      low_part = 64'(snap.last)
               + (64'((snap.len > LEN_W'(2)) ? snap.sec : 8'h00) << 8)
               + (64'(snap.len) << 16)
               + (64'(snap.first) << 24);
    end
    high_part = ((snap.len > LEN_W'(3)) ? snap.mid : 32'h0) + snap.ext_hash;
    sum       = low_part + {high_part, 32'h0};
    unique case (snap.ext_kind)
      EXT_NIF: hash_nxt = sum ^ FLIP_NIF;
      EXT_KF:  hash_nxt = sum ^ FLIP_KF;
      EXT_DDS: hash_nxt = sum ^ FLIP_DDS;
      EXT_WAV: hash_nxt = sum ^ FLIP_WAV;
      default: hash_nxt = sum;
    endcase
    if (snap.ovf) begin
      hash_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && out_free) begin
      hash_r     <= hash_nxt;
      too_long_r <= snap.ovf;
    end
  end

endmodule
`default_nettype wire

### rtl/core/archive_filename_hash.sv
`default_nettype none
// Archive file-name hash. Path bytes (in_tuser[0] = 0) and then file-name
// bytes (in_tuser[0] = 1) stream in one per beat; in_tuser[1] = 0 marks a beat
// without a character, and in_tlast ends the name and causes exactly one
// result beat carrying the 64-bit hash, with out_tuser[0] set when the joined
// name ran past 1023 characters (the hash is then zero). One beat is taken
// every clock cycle unless the input stalls as below: each beat passes an
// input register, one state-update stage (one multiply-add by the hash
// constant per path) that fills the snapshot register, and an output register.
// Input beats stall only while a last beat waits with both the snapshot
// register and the output register still holding untaken results.
module archive_filename_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic [1:0]  in_tuser,   // [0] is_file, [1] has_char
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] hash_value
  output logic [0:0]       out_tuser   // [0] too_long
);
  import afh_pkg::*;

  logic      v1_r;
  afh_beat_t beat_r;
  logic      take;
  logic      snap_valid;
  afh_snap_t snap;
  logic      out_free;
  logic      too_long;

  assign in_tready = !v1_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      v1_r <= 1'b1;
    end else if (take) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r.char_byte <= in_tdata;
      beat_r.is_file   <= in_tuser[0];
      beat_r.has_char  <= in_tuser[1];
      beat_r.is_last   <= in_tlast;
    end
  end

  afh_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (v1_r),
    .beat       (beat_r),
    .out_free   (out_free),
    .take       (take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  afh_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hash_value (out_tdata),
    .too_long   (too_long)
  );

  assign out_tuser[0] = too_long;

  // An overlong name always reports a zero hash.
  a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 64'h0)
    else $error("too_long result with nonzero hash");

  // Input back-pressure only comes from a held last beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && beat_r.is_last && snap_valid)
    else $error("input stalled without a pending last beat");

  // A waiting snapshot is not dropped while the output is blocked.
  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid && !out_free |=> snap_valid)
    else $error("snapshot lost while output blocked");

  // A snapshot moving on always lands in the output register.
  a_snap_move: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid && out_free |=> out_tvalid)
    else $error("snapshot moved but no result shown");

endmodule
`default_nettype wire

### tb/tb.sv
module tb;
  import afh_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CHARS   = 900;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_file;
    logic       has_ch;
    logic       last;
    logic       drain;
  } name_beat_t;

  typedef struct packed {
    logic [63:0] hash;
    logic        too_long;
  } name_hash_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'b00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  archive_filename_hash DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  name_beat_t pending_beats[$];
  name_hash_t expected_hashes[$];

  int  errors = 0;
  int  cycle_count = 0;
  int  idle_cycles = 0;
  int  beats_taken = 0;
  int  total_beats = 0;
  int  random_chars = 0;
  int  chars_before_long = 0;
  bit  long_done = 1'b0;
  bit  in_taken = 1'b0;
  bit  next_drain = 1'b0;
  logic calm;

  // Neither side inserts random idles inside this window.
  assign calm = (cycle_count >= 3000) && (cycle_count < 4500);

  // Running summary of the joined name, plus the copy taken at the last dot.
  logic [LEN_W-1:0] nm_len;
  logic [7:0]       nm_first, nm_last, nm_sec;
  logic [31:0]      nm_mid;
  logic             dot_seen;
  logic [LEN_W-1:0] stem_len;
  logic [31:0]      stem_mid;
  logic [7:0]       stem_last, stem_sec;
  logic [31:0]      ext_h;
  logic [2:0]       ext_len;
  logic [23:0]      ext_tail;
  logic             path_nonempty, file_started, len_ovf;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic clear_name();
    nm_len = '0; nm_first = '0; nm_last = '0; nm_sec = '0; nm_mid = '0;
    dot_seen = 1'b0; stem_len = '0; stem_mid = '0; stem_last = '0; stem_sec = '0;
    ext_h = '0; ext_len = '0; ext_tail = '0;
    path_nonempty = 1'b0; file_started = 1'b0; len_ovf = 1'b0;
  endtask

  function automatic logic [31:0] mix32(logic [31:0] h, logic [7:0] c);
    logic [63:0] p;
    p = {32'd0, h} * 64'h1003F + {56'd0, c};
    return p[31:0];
  endfunction

  task automatic append_char(logic [7:0] c);
    if (nm_len >= 3) nm_mid = mix32(nm_mid, nm_sec);
    if (nm_len == 0) nm_first = c;
    nm_sec  = nm_last;
    nm_last = c;
    if (nm_len >= LEN_W'(MAX_LEN)) begin
      len_ovf = 1'b1;
      nm_len  = LEN_W'(MAX_LEN + 1);
    end else begin
      nm_len = nm_len + 1'b1;
    end
  endtask

  function automatic afh_ext_t ext_class();
    if (ext_len == 3 && ext_tail == EXT_CH_NIF) return EXT_NIF;
    if (ext_len == 2 && ext_tail == EXT_CH_KF)  return EXT_KF;
    if (ext_len == 3 && ext_tail == EXT_CH_DDS) return EXT_DDS;
    if (ext_len == 3 && ext_tail == EXT_CH_WAV) return EXT_WAV;
    return EXT_OTHER;
  endfunction

  function automatic logic [63:0] name_hash();
    logic [63:0] len, lastc, sec, mid, h;
    len   = dot_seen ? 64'(stem_len) : 64'(nm_len);
    lastc = dot_seen ? 64'(stem_last) : 64'(nm_last);
    sec   = dot_seen ? 64'(stem_sec) : 64'(nm_sec);
    mid   = dot_seen ? 64'(stem_mid) : 64'(nm_mid);
    h = '0;
    if (len > 0) begin
      h = lastc + ((len > 2) ? sec : 64'd0) * 64'h100 + len * 64'h10000
          + 64'(nm_first) * 64'h100_0000;
      if (len > 3) h = h + (mid << 32);
    end
    if (dot_seen) begin
      h = h + {ext_h, 32'd0};
      case (ext_class())
        EXT_NIF: h = h ^ FLIP_NIF;
        EXT_KF:  h = h ^ FLIP_KF;
        EXT_DDS: h = h ^ FLIP_DDS;
        EXT_WAV: h = h ^ FLIP_WAV;
        default: h = h;
      endcase
    end
    return h;
  endfunction

  task automatic absorb_beat(name_beat_t b);
    logic [7:0] c;
    logic       first;
    name_hash_t e;
    c = b.ch;
    if (b.has_ch && c != 8'h00) begin
      if (!b.is_file) begin
        // Path characters are dropped once the file part has begun.
        if (!file_started) begin
          path_nonempty = 1'b1;
          append_char(c);
        end
      end else begin
        first = !file_started;
        if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;
        if (c == CH_SLASH) c = CH_BSLASH;
        file_started = 1'b1;
        if (c == CH_DOT) begin
          stem_len  = nm_len;
          stem_mid  = nm_mid;
          stem_last = nm_last;
          stem_sec  = nm_sec;
          dot_seen  = 1'b1;
          ext_h     = 32'(CH_DOT);
          ext_len   = '0;
          ext_tail  = '0;
        end else if (dot_seen) begin
          ext_h = mix32(ext_h, c);
          if (ext_len < 7) ext_len = ext_len + 1'b1;
          ext_tail = {ext_tail[15:0], c};
        end
        if (first && path_nonempty) append_char(CH_BSLASH);
        append_char(c);
      end
    end
    if (b.last) begin
      if (len_ovf) begin
        e.hash     = '0;
        e.too_long = 1'b1;
      end else begin
        e.hash     = name_hash();
        e.too_long = 1'b0;
      end
      expected_hashes.push_back(e);
      clear_name();
    end
  endtask

  task automatic add_beat(logic [7:0] ch, logic is_file, logic has_ch, logic last);
    name_beat_t b;
    b.ch = ch; b.is_file = is_file; b.has_ch = has_ch; b.last = last;
    b.drain = next_drain;
    next_drain = 1'b0;
    if (has_ch && ch != 8'h00) random_chars++;
    pending_beats.push_back(b);
  endtask

  task automatic add_text(string s, logic is_file, logic end_here);
    for (int i = 0; i < s.len(); i++)
      add_beat(s[i], is_file, 1'b1, end_here && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 2) == 0) return c - CASE_OFS;
    return c;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return mixed_case(8'h61 + 8'($urandom_range(0, 25)));
    if (r < 68) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 71) return CH_SLASH;
    if (r < 74) return CH_BSLASH;
    if (r < 77) return CH_DOT;
    if (r < 79) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic add_ext(string s);
    for (int i = 0; i < s.len(); i++) add_beat(mixed_case(s[i]), 1'b1, 1'b1, 1'b0);
  endtask

  // Occasional beats that a well-formed name would not carry.
  task automatic maybe_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)      add_beat(8'($urandom), 1'($urandom), 1'b0, 1'b0);
    else if (r < 5) add_beat(8'h00, 1'($urandom), 1'b1, 1'b0);
    else if (r < 7) add_beat(pick_char(), 1'b0, 1'b1, 1'b0);
  endtask

  task automatic queue_random_name();
    int         plen, slen, kind, xlen, start;
    name_beat_t b;
    if ($urandom_range(0, 11) == 0) next_drain = 1'b1;
    start = pending_beats.size();
    plen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    slen = $urandom_range(0, 7);
    kind = $urandom_range(0, 7);
    for (int i = 0; i < plen; i++) begin
      maybe_noise();
      add_beat(pick_char(), 1'b0, 1'b1, 1'b0);
    end
    for (int i = 0; i < slen; i++) begin
      maybe_noise();
      add_beat(pick_char(), 1'b1, 1'b1, 1'b0);
    end
    case (kind)
      1: add_ext(".nif");
      2: add_ext(".kf");
      3: add_ext(".dds");
      4: add_ext(".wav");
      5, 6: begin
        add_beat(CH_DOT, 1'b1, 1'b1, 1'b0);
        xlen = $urandom_range(0, 9);
        for (int i = 0; i < xlen; i++) add_beat(pick_char(), 1'b1, 1'b1, 1'b0);
      end
      7: begin
        add_ext(".d");
        add_ext(($urandom_range(0, 1) == 0) ? ".wav" : ".ni");
      end
      default: ;
    endcase
    maybe_noise();
    if (pending_beats.size() > start && $urandom_range(0, 3) != 0) begin
      b = pending_beats.pop_back();
      b.last = 1'b1;
      pending_beats.push_back(b);
    end else begin
      add_beat(8'($urandom), 1'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic queue_long_name(int n_path, int n_file, string ext);
    for (int i = 0; i < n_path; i++)
      add_beat(8'h61 + 8'($urandom_range(0, 25)), 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < n_file; i++)
      add_beat(8'h41 + 8'($urandom_range(0, 25)), 1'b1, 1'b1, 1'b0);
    add_ext(ext);
    add_beat(8'h00, 1'b1, 1'b0, 1'b1);
  endtask

  // Driver: a beat stays on the bus until it is taken.
  always @(negedge clk) begin : drive_in
    bit         go;
    name_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else begin
      in_taken = 1'b0;
      go = pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 8);
      if (go && pending_beats[0].drain && expected_hashes.size() != 0) go = 1'b0;
      if (go) begin
        nb = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nb.ch;
        in_tuser  <= {nb.has_ch, nb.is_file};
        in_tlast  <= nb.last;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        in_tuser  <= 2'($urandom);
        in_tlast  <= 1'($urandom);
      end
    end
  end

  always @(negedge clk) begin : drive_out_ready
    out_tready <= rst_n && (calm || $urandom_range(0, 99) >= 8);
  end

  // Monitor: checks result beats and feeds taken input beats to the predictor.
  always @(posedge clk) begin : monitor
    name_beat_t b;
    name_hash_t e;
    bit         moved;
    cycle_count++;
    moved = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (expected_hashes.size() == 0) begin
          report_mismatch($sformatf("unexpected result hash=%h too_long=%b",
                                    out_tdata, out_tuser[0]));
        end else begin
          e = expected_hashes.pop_front();
          if (out_tdata !== e.hash)
            report_mismatch($sformatf("hash_value got %h want %h", out_tdata, e.hash));
          if (out_tuser[0] !== e.too_long)
            report_mismatch($sformatf("too_long got %b want %b", out_tuser[0], e.too_long));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        in_taken = 1'b1;
        beats_taken++;
        b.ch = in_tdata; b.is_file = in_tuser[0]; b.has_ch = in_tuser[1];
        b.last = in_tlast; b.drain = 1'b0;
        absorb_beat(b);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_name();

    // Directed names: empty name, joined path with an uppercase .nif, the
    // other three special extensions, a slash in the file part, and a name
    // with a NUL byte, a path byte after the file part and a closing beat
    // without a character.
    add_beat(8'h00, 1'b0, 1'b0, 1'b1);
    add_text("Q", 1'b0, 1'b0);
    add_text("ab.NIF", 1'b1, 1'b1);
    add_text("k.kf", 1'b1, 1'b1);
    add_text("/.dDs", 1'b1, 1'b1);
    add_text("w.WAV", 1'b1, 1'b1);
    add_beat(8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b1, 1'b0);
    add_beat(8'hFF, 1'b1, 1'b1, 1'b0);
    add_text("z", 1'b0, 1'b0);
    add_beat(8'hA5, 1'b1, 1'b0, 1'b1);

    // The random part starts only once the directed results are all in.
    next_drain = 1'b1;
    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      queue_random_name();
      if (!long_done && random_chars >= 300) begin
        // Names right at and just past the length limit.
        long_done = 1'b1;
        chars_before_long = random_chars;
        queue_long_name(MAX_LEN, 0, "");
        queue_long_name(MAX_LEN - 1, 1, "");
        queue_long_name(0, MAX_LEN - 4, ".dds");
        queue_long_name(0, MAX_LEN + 7, "");
        random_chars = chars_before_long;
      end
    end
    total_beats = pending_beats.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_taken < total_beats) @(posedge clk);
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### archive_filename_hash.f
rtl/core/afh_pkg.sv
rtl/core/afh_state.sv
rtl/core/afh_final.sv
rtl/core/archive_filename_hash.sv
tb/tb.sv
